// ===== rtl/trtcm_pkg.sv =====
// shared types and constants for the two-rate three-color marker
package trtcm_pkg;

	// field widths
	localparam int TIME_W  = 32;
	localparam int BYTES_W = 16;
	localparam int TOKEN_W = 31;
	localparam int COLOR_W = 2;
	localparam int CFG_INDEX_W = 2;

	// bucket lanes
	localparam int LANES       = 2;
	localparam int LANE_PEAK   = 0;
	localparam int LANE_COMMIT = 1;

	// refill divide: rate * elapsed / 8000000 = ((rate * elapsed) >> 9) / 15625
	localparam int PROD_W      = TOKEN_W + TIME_W;
	localparam int PRE_SHIFT   = 9;
	localparam int QUOT_W      = PROD_W - PRE_SHIFT;
	localparam int CHUNK_W     = QUOT_W / 3;
	localparam int REM_W       = 14;
	localparam int DIVN_W      = REM_W + CHUNK_W;
	localparam int RECIP_W     = 33;
	localparam int RECIP_SHIFT = 46;
	localparam int OVER_W      = QUOT_W - TOKEN_W;
	localparam logic [RECIP_W-1:0] RECIP  = 33'd4503599628;
	localparam logic [REM_W-1:0]   DIV_LO = 14'd15625;

	// queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_PEAK_RATE    = 2'd0,
		REG_PEAK_BURST   = 2'd1,
		REG_COMMIT_RATE  = 2'd2,
		REG_COMMIT_BURST = 2'd3
	} reg_index_t;

	typedef enum logic [COLOR_W-1:0] {
		COLOR_GREEN  = 2'd0,
		COLOR_YELLOW = 2'd1,
		COLOR_RED    = 2'd2
	} color_t;

	typedef struct packed {
		logic               en;
		reg_index_t         index;
		logic [TOKEN_W-1:0] data;
	} cfg_wr_t;

	typedef struct packed {
		logic [TIME_W-1:0]  elapsed;
		logic [BYTES_W-1:0] bytes;
	} queue_entry_t;

	typedef struct packed {
		logic         valid;
		queue_entry_t entry;
	} queue_push_t;

endpackage

// ===== rtl/trtcm_front.sv =====
// front end: takes packets, works out elapsed time, pushes them to the queue
module trtcm_front import trtcm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [TIME_W-1:0]  arrival_time,
	input  logic [BYTES_W-1:0] packet_bytes,
	input  logic               q_full,
	output queue_push_t        q_push
);

	logic [TIME_W-1:0] last_arrival_q;
	logic              xfer;

	assign in_ready = !q_full;
	assign xfer     = in_valid && in_ready;

	// elapsed time wraps modulo 2^32
	assign q_push.valid         = xfer;
	assign q_push.entry.elapsed = arrival_time - last_arrival_q;
	assign q_push.entry.bytes   = packet_bytes;

	// remember the arrival time of every transfer, red ones too
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_arrival_q <= '0;
		end else if (xfer) begin
			last_arrival_q <= arrival_time;
		end
	end

endmodule

// ===== rtl/trtcm_queue.sv =====
// short register queue between front and back ends
module trtcm_queue import trtcm_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  queue_push_t  push,
	output logic         full,
	input  logic         pop,
	output logic         not_empty,
	output queue_entry_t head
);

	queue_entry_t           entries_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_PTR_W:0]   count_q;

	assign full      = (count_q == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = entries_q[rd_ptr_q];

	// storage, no reset needed
	always_ff @(posedge clk) begin
		if (push.valid) begin
			entries_q[wr_ptr_q] <= push.entry;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push.valid, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/trtcm_back.sv =====
// back end: refill divide pipeline, token buckets and color output register
module trtcm_back import trtcm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_wr_t            cfg_wr,
	input  logic               q_valid,
	input  queue_entry_t       q_head,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [COLOR_W-1:0] color
);

	// one quotient digit of n / 15625 by reciprocal multiply, exact for 32-bit n
	function automatic logic [CHUNK_W-1:0] div_step(input logic [DIVN_W-1:0] n);
		logic [DIVN_W+RECIP_W-1:0] p;
		p = (DIVN_W+RECIP_W)'(n) * (DIVN_W+RECIP_W)'(RECIP);
		return p[RECIP_SHIFT +: CHUNK_W];
	endfunction

	// remainder of that digit, taken modulo 2^14 since it stays below 15625
	function automatic logic [REM_W-1:0] div_rem(input logic [REM_W-1:0] nlo,
		input logic [CHUNK_W-1:0] q);
		logic [DIVN_W-1:0] qd;
		qd = DIVN_W'(q) * DIVN_W'(DIV_LO);
		return nlo - qd[REM_W-1:0];
	endfunction

	// configuration and bucket state
	logic [TOKEN_W-1:0] rate_q  [LANES];
	logic [TOKEN_W-1:0] burst_q [LANES];
	logic [TOKEN_W-1:0] tok_q   [LANES];

	// pipeline
	logic                 v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic [BYTES_W-1:0]   bytes_s1, bytes_s2, bytes_s3, bytes_s4, bytes_s5, bytes_s6;
	logic [PROD_W-1:0]    prod_s1  [LANES];
	logic [CHUNK_W-1:0]   q2_s2    [LANES];
	logic [REM_W-1:0]     nlo_s2   [LANES];
	logic [2*CHUNK_W-1:0] xlo_s2   [LANES];
	logic [DIVN_W-1:0]    n1_s3    [LANES];
	logic [CHUNK_W-1:0]   qh_s3    [LANES];
	logic [CHUNK_W-1:0]   c0_s3    [LANES];
	logic [CHUNK_W-1:0]   q1_s4    [LANES];
	logic [REM_W-1:0]     nlo_s4   [LANES];
	logic [CHUNK_W-1:0]   qh_s4    [LANES];
	logic [CHUNK_W-1:0]   c0_s4    [LANES];
	logic [DIVN_W-1:0]    n0_s5    [LANES];
	logic [2*CHUNK_W-1:0] qh_s5    [LANES];
	logic                 over_s6  [LANES];
	logic [TOKEN_W-1:0]   glow_s6  [LANES];

	logic                 out_valid_q;
	color_t               color_q;

	logic                 adv;
	logic [QUOT_W-1:0]    x_s1     [LANES];
	logic [DIVN_W-1:0]    n2_s1    [LANES];
	logic [QUOT_W-1:0]    gain_s5  [LANES];
	logic [TOKEN_W:0]     sum      [LANES];
	logic [TOKEN_W-1:0]   refilled [LANES];
	logic [TOKEN_W-1:0]   tok_next [LANES];
	logic [TOKEN_W-1:0]   size;
	color_t               color_next;

	// the whole pipeline moves when the output register can take a result
	assign adv       = !out_valid_q || out_ready;
	assign q_pop     = adv && q_valid;
	assign out_valid = out_valid_q;
	assign color     = color_q;

	// divide digit inputs
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			x_s1[l]    = prod_s1[l][PROD_W-1:PRE_SHIFT];
			n2_s1[l]   = DIVN_W'(x_s1[l][2*CHUNK_W +: CHUNK_W]);
			gain_s5[l] = {qh_s5[l], div_step(n0_s5[l])};
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s1 <= q_pop;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// payload: rate multiply, then three long-division digits by 15625
	always_ff @(posedge clk) begin
		if (adv) begin
			bytes_s1 <= q_head.bytes;
			bytes_s2 <= bytes_s1;
			bytes_s3 <= bytes_s2;
			bytes_s4 <= bytes_s3;
			bytes_s5 <= bytes_s4;
			bytes_s6 <= bytes_s5;
			for (int l = 0; l < LANES; l++) begin
				prod_s1[l] <= PROD_W'(rate_q[l]) * PROD_W'(q_head.elapsed);
				q2_s2[l]   <= div_step(n2_s1[l]);
				nlo_s2[l]  <= n2_s1[l][REM_W-1:0];
				xlo_s2[l]  <= x_s1[l][2*CHUNK_W-1:0];
				n1_s3[l]   <= {div_rem(nlo_s2[l], q2_s2[l]), xlo_s2[l][CHUNK_W +: CHUNK_W]};
				qh_s3[l]   <= q2_s2[l];
				c0_s3[l]   <= xlo_s2[l][CHUNK_W-1:0];
				q1_s4[l]   <= div_step(n1_s3[l]);
				nlo_s4[l]  <= n1_s3[l][REM_W-1:0];
				qh_s4[l]   <= qh_s3[l];
				c0_s4[l]   <= c0_s3[l];
				n0_s5[l]   <= {div_rem(nlo_s4[l], q1_s4[l]), c0_s4[l]};
				qh_s5[l]   <= {qh_s4[l], q1_s4[l]};
				over_s6[l] <= |gain_s5[l][QUOT_W-1:TOKEN_W];
				glow_s6[l] <= gain_s5[l][TOKEN_W-1:0];
			end
		end
	end

	// refill with saturation, then mark and debit
	always_comb begin
		size = TOKEN_W'(bytes_s6);
		for (int l = 0; l < LANES; l++) begin
			sum[l] = {1'b0, tok_q[l]} + {1'b0, glow_s6[l]};
			if (over_s6[l] || sum[l] > {1'b0, burst_q[l]}) begin
				refilled[l] = burst_q[l];
			end else begin
				refilled[l] = sum[l][TOKEN_W-1:0];
			end
			tok_next[l] = refilled[l];
		end
		priority if (refilled[LANE_PEAK] < size) begin
			color_next = COLOR_RED;
		end else if (refilled[LANE_COMMIT] < size) begin
			color_next = COLOR_YELLOW;
			tok_next[LANE_PEAK] = refilled[LANE_PEAK] - size;
		end else begin
			color_next = COLOR_GREEN;
			tok_next[LANE_PEAK]   = refilled[LANE_PEAK] - size;
			tok_next[LANE_COMMIT] = refilled[LANE_COMMIT] - size;
		end
	end

	// registers and buckets; a burst write also fills its bucket
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < LANES; l++) begin
				rate_q[l]  <= '0;
				burst_q[l] <= '0;
				tok_q[l]   <= '0;
			end
		end else if (cfg_wr.en) begin
			unique case (cfg_wr.index)
				REG_PEAK_RATE: begin
					rate_q[LANE_PEAK] <= cfg_wr.data;
				end
				REG_PEAK_BURST: begin
					burst_q[LANE_PEAK] <= cfg_wr.data;
					tok_q[LANE_PEAK]   <= cfg_wr.data;
				end
				REG_COMMIT_RATE: begin
					rate_q[LANE_COMMIT] <= cfg_wr.data;
				end
				REG_COMMIT_BURST: begin
					burst_q[LANE_COMMIT] <= cfg_wr.data;
					tok_q[LANE_COMMIT]   <= cfg_wr.data;
				end
			endcase
		end else if (adv && v_s6) begin
			for (int l = 0; l < LANES; l++) begin
				tok_q[l] <= tok_next[l];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			color_q     <= COLOR_GREEN;
		end else if (adv) begin
			out_valid_q <= v_s6;
			if (v_s6) begin
				color_q <= color_next;
			end
		end
	end

	// buckets never hold more than their burst size
	a_peak_cap: assert property (@(posedge clk) disable iff (!arst_n)
		tok_q[LANE_PEAK] <= burst_q[LANE_PEAK])
		else $error("peak bucket above burst size");

	a_commit_cap: assert property (@(posedge clk) disable iff (!arst_n)
		tok_q[LANE_COMMIT] <= burst_q[LANE_COMMIT])
		else $error("committed bucket above burst size");

	// a stalled last stage keeps its packet
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv && v_s6 |=> v_s6 && $stable(bytes_s6))
		else $error("last stage lost a packet during stall");

	// a packet leaving the last stage lands in the output register
	a_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv && v_s6 |=> out_valid_q)
		else $error("result dropped on its way to the output");

endmodule

// ===== rtl/two_rate_three_color_marker_unit.sv =====
// Color-blind two-rate three-color marker: one color per packet from a peak and a
// committed token bucket, refilled by rate * elapsed microseconds / 8000000 and
// capped at the burst sizes. A new packet is taken every cycle while the four-entry
// queue has room. The transfer writes the queue, then come the rate multiply, five
// stages for three reciprocal-multiply division digits and the output register; the
// bucket update feeds the bucket registers back through combinational logic, so the
// sustained rate is one packet per cycle while the output is not stalled.
// A stalled output holds the whole back end. Configure only while no packet is in flight.
module two_rate_three_color_marker_unit import trtcm_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [TIME_W-1:0]      arrival_time,
	input  logic [BYTES_W-1:0]     packet_bytes,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [COLOR_W-1:0]     color,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [TOKEN_W-1:0]     cfg_data
);

	cfg_wr_t      cfg_wr;
	queue_push_t  q_push;
	queue_entry_t q_head;
	logic         q_full;
	logic         q_not_empty;
	logic         q_pop;

	assign cfg_wr.en    = cfg_we;
	assign cfg_wr.index = reg_index_t'(cfg_index);
	assign cfg_wr.data  = cfg_data;

	trtcm_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.arrival_time (arrival_time),
		.packet_bytes (packet_bytes),
		.q_full       (q_full),
		.q_push       (q_push)
	);

	trtcm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	trtcm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg_wr),
		.q_valid   (q_not_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.color     (color)
	);

endmodule
